>>> hdl/pdg_pkg.sv
// ============================================================================
// pdg_pkg
// Shared constants, codes and widths of the Poisson-disk acceptance grid.
// ============================================================================
`default_nettype none

package pdg_pkg;

    // Grid and store sizes
    localparam int GRID_SIDE  = 64;
    localparam int MAX_POINTS = 1024;
    localparam int COORD_BITS = 24;

    localparam int CELLS   = GRID_SIDE * GRID_SIDE;
    localparam int CELL_AW = $clog2(CELLS);
    localparam int PIDX_W  = $clog2(MAX_POINTS);
    localparam int CNT_W   = PIDX_W + 1;

    // Configuration register widths
    localparam int DIM_W    = 7;
    localparam int DIST_W   = 48;
    localparam int INV_W    = 24;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 48;

    // Largest usable grid dimension in a DIM_W register
    localparam int DIM_CAP  = (GRID_SIDE > 127) ? 127 : GRID_SIDE;

    // Shared multiplier: coordinate (Q16.8) times inverse cell size (Q8.16)
    localparam int MUL_W    = (COORD_BITS > INV_W) ? COORD_BITS : INV_W;
    localparam int PROD_W   = 2 * MUL_W;
    localparam int FRAC_SH  = 24;

    // Signed-safe neighbor coordinate width
    localparam int NB_W     = COORD_BITS + 2;

    // Point store word: {cell address, y, x}
    localparam int PT_W     = CELL_AW + 2 * COORD_BITS;

    // Stream widths
    localparam int IN_DATA_W  = ((2 * COORD_BITS + 7) / 8) * 8;
    localparam int OUT_RAW_W  = 2 + PIDX_W + CNT_W;
    localparam int OUT_DATA_W = ((OUT_RAW_W + 7) / 8) * 8;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_GRID_WIDTH    = 2'd0,
        REG_GRID_HEIGHT   = 2'd1,
        REG_MIN_DIST_SQ   = 2'd2,
        REG_INV_CELL_SIZE = 2'd3
    } t_cfg_reg;

    // Result status codes
    typedef enum logic [1:0] {
        ST_ACCEPT    = 2'd0,
        ST_TOO_CLOSE = 2'd1,
        ST_OUTSIDE   = 2'd2,
        ST_FULL      = 2'd3
    } t_status;

    // Item kinds carried in tuser
    localparam logic OP_CLEAR  = 1'b0;
    localparam logic OP_INSERT = 1'b1;

endpackage

`default_nettype wire

>>> hdl/pdg_ram.sv
// ============================================================================
// pdg_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ============================================================================
`default_nettype none

module pdg_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = $clog2(DEPTH)
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read, holds while not enabled
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

>>> hdl/poisson_disk_grid_insert_top.sv
// ============================================================================
// poisson_disk_grid_insert_top
// Acceptance grid of Bridson Poisson-disk sampling: cell lookup, 5x5
// neighborhood distance check and point insertion.
// ============================================================================
//
// Usage
//   Input stream (s_axis): tuser is the item kind (0 clear, 1 insert),
//   tdata carries x in the low 24 bits and y above it, both unsigned Q16.8.
//   Output stream (m_axis): one item per input item with status, the index
//   given to an accepted point and the stored point count.
//   Configuration is a plain write port (index 0..3: grid width, grid height,
//   minimum distance squared, inverse cell size); write it only while idle.
// Sequencing
//   One item at a time; tready is high only while the sequencer is idle.
//   A clear goes straight to the result. An insert computes its cell
//   (x, then y, times the inverse cell size, then the row base) and visits
//   each of the 25 neighbor cells: one off the grid is skipped, an empty
//   one ends at the cell-table read, a point of another cell at the chained
//   point-store read, else a full distance check follows; a too-close
//   point ends the scan at once; then the item is decided and handed over.
//   The one shared 24x24 multiplier and the chained table reads set its pace.
// Reset and stall
//   Reset empties the grid (point count zero) and loads the register
//   defaults; no clearing pass is needed since a cell counts as occupied
//   only when its point index is below the count and that point records
//   the same cell. A stalled output holds the result register and the
//   sequencer waits before taking the next item.
// ============================================================================
`default_nettype none

module poisson_disk_grid_insert_top (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    // config write port
    input  wire logic                              i_cfg_we,
    input  wire logic [pdg_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  wire logic [pdg_pkg::CFG_DATA_W-1:0]    i_cfg_wdata,
    // input items
    input  wire logic                              i_s_tvalid,
    output logic                                   o_s_tready,
    input  wire logic [pdg_pkg::IN_DATA_W-1:0]     i_s_tdata,  // x_coord, y_coord
    input  wire logic                              i_s_tuser,  // opcode
    // result items
    output logic                                   o_m_tvalid,
    input  wire logic                              i_m_tready,
    output logic      [pdg_pkg::OUT_DATA_W-1:0]    o_m_tdata   // status, point_index,
                                                               // point_count
);

    import pdg_pkg::*;

    typedef enum logic [11:0] {
        S_IDLE   = 12'b0000_0000_0001,
        S_MULX   = 12'b0000_0000_0010,
        S_MULY   = 12'b0000_0000_0100,
        S_BASE   = 12'b0000_0000_1000,
        S_ROW    = 12'b0000_0001_0000,
        S_NB     = 12'b0000_0010_0000,
        S_CELL   = 12'b0000_0100_0000,
        S_PT     = 12'b0000_1000_0000,
        S_DY     = 12'b0001_0000_0000,
        S_CMP    = 12'b0010_0000_0000,
        S_DECIDE = 12'b0100_0000_0000,
        S_DONE   = 12'b1000_0000_0000
    } t_state;

    // configuration registers
    logic [DIM_W-1:0]   r_gw_cfg;
    logic [DIM_W-1:0]   r_gh_cfg;
    logic [DIST_W-1:0]  r_min_dist;
    logic [INV_W-1:0]   r_inv;

    // sequencer and datapath registers
    t_state                 r_state, n_state;
    logic [COORD_BITS-1:0]  r_x, r_y, r_cx, r_cy;
    logic [2:0]             r_dxi, n_dxi, r_dyi, n_dyi;
    logic [CELL_AW-1:0]     r_rowbase, n_rowbase, r_base0, r_caddr;
    logic [PROD_W-1:0]      r_mul, r_acc;
    logic                   r_close, n_close;
    logic [CNT_W-1:0]       r_count;
    t_status                r_res_status;
    logic [PIDX_W-1:0]      r_res_idx;

    // output register
    logic                   r_out_valid;
    t_status                r_out_status;
    logic [PIDX_W-1:0]      r_out_idx;
    logic [CNT_W-1:0]       r_out_count;

    // combinational
    logic [DIM_W-1:0]       gw, gh;
    logic                   in_acc, out_free, step;
    logic [MUL_W-1:0]       mul_a, mul_b;
    logic [NB_W-1:0]        nx, ny;
    logic                   nb_in;
    logic [CELL_AW-1:0]     nb_addr, own_addr, cy_m2;
    logic                   cell_re, cell_we, pt_re, pt_we;
    logic [PIDX_W-1:0]      cell_rdata;
    logic [PT_W-1:0]        pt_rdata;
    logic                   cell_live, pt_match;
    logic [COORD_BITS-1:0]  px, py, dx, dy;
    logic [PROD_W:0]        dist_sum;
    logic                   dist_lt, outside, insert_ok;

    assign in_acc   = i_s_tvalid && o_s_tready;
    assign out_free = !r_out_valid || i_m_tready;

    // effective grid dimensions, saturated to the grid side
    assign gw = (r_gw_cfg > DIM_W'(DIM_CAP)) ? DIM_W'(DIM_CAP) : r_gw_cfg;
    assign gh = (r_gh_cfg > DIM_W'(DIM_CAP)) ? DIM_W'(DIM_CAP) : r_gh_cfg;

    // neighbor position; negative values wrap high and fail the bound check
    assign nx      = {2'b00, r_cx} + NB_W'(r_dxi) - NB_W'(2);
    assign ny      = {2'b00, r_cy} + NB_W'(r_dyi) - NB_W'(2);
    assign nb_in   = (nx < NB_W'(gw)) && (ny < NB_W'(gh));
    assign nb_addr = r_rowbase + CELL_AW'(nx);

    // own cell: row base of offset -2, plus two rows, plus cx (modulo table size)
    assign own_addr = r_base0 + CELL_AW'({gw, 1'b0}) + CELL_AW'(r_cx);
    assign cy_m2    = CELL_AW'(r_mul[PROD_W-1:FRAC_SH]) - CELL_AW'(2);

    // occupancy and point decode
    assign cell_live = ({1'b0, cell_rdata} < r_count);
    assign pt_match  = (pt_rdata[PT_W-1 -: CELL_AW] == r_caddr);
    assign px        = pt_rdata[COORD_BITS-1:0];
    assign py        = pt_rdata[2*COORD_BITS-1:COORD_BITS];
    assign dx        = (r_x >= px) ? (r_x - px) : (px - r_x);
    assign dy        = (r_y >= py) ? (r_y - py) : (py - r_y);

    // distance compare: dx^2 + dy^2 < limit
    assign dist_sum  = {1'b0, r_acc} + {1'b0, r_mul};
    assign dist_lt   = dist_sum < (PROD_W+1)'(r_min_dist);

    assign outside   = (r_cx >= COORD_BITS'(gw)) || (r_cy >= COORD_BITS'(gh));
    assign insert_ok = !r_close && !outside && (r_count < CNT_W'(MAX_POINTS));

    // sequencer and shared multiplier operand select
    always_comb begin
        n_state   = r_state;
        n_dxi     = r_dxi;
        n_dyi     = r_dyi;
        n_rowbase = r_rowbase;
        n_close   = r_close;
        mul_a     = '0;
        mul_b     = '0;
        cell_re   = 1'b0;
        cell_we   = 1'b0;
        pt_re     = 1'b0;
        pt_we     = 1'b0;
        step      = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_state = (i_s_tuser == OP_INSERT) ? S_MULX : S_DONE;
                end
            end
            S_MULX: begin
                mul_a   = MUL_W'(r_x);
                mul_b   = MUL_W'(r_inv);
                n_state = S_MULY;
            end
            S_MULY: begin
                mul_a   = MUL_W'(r_y);
                mul_b   = MUL_W'(r_inv);
                n_state = S_BASE;
            end
            S_BASE: begin
                mul_a   = MUL_W'(cy_m2);
                mul_b   = MUL_W'(gw);
                n_state = S_ROW;
            end
            S_ROW: begin
                n_rowbase = r_mul[CELL_AW-1:0];
                n_dxi     = '0;
                n_dyi     = '0;
                n_close   = 1'b0;
                n_state   = S_NB;
            end
            S_NB: begin
                if (nb_in) begin
                    cell_re = 1'b1;
                    n_state = S_CELL;
                end else begin
                    step = 1'b1;
                end
            end
            S_CELL: begin
                if (cell_live) begin
                    pt_re   = 1'b1;
                    n_state = S_PT;
                end else begin
                    step = 1'b1;
                end
            end
            S_PT: begin
                if (pt_match) begin
                    mul_a   = MUL_W'(dx);
                    mul_b   = MUL_W'(dx);
                    n_state = S_DY;
                end else begin
                    step = 1'b1;
                end
            end
            S_DY: begin
                mul_a   = MUL_W'(dy);
                mul_b   = MUL_W'(dy);
                n_state = S_CMP;
            end
            S_CMP: begin
                if (dist_lt) begin
                    n_close = 1'b1;
                    n_state = S_DECIDE;
                end else begin
                    step = 1'b1;
                end
            end
            S_DECIDE: begin
                if (insert_ok) begin
                    cell_we = 1'b1;
                    pt_we   = 1'b1;
                end
                n_state = S_DONE;
            end
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // walk the 5x5 neighborhood, row by row
        if (step) begin
            if (r_dxi == 3'd4) begin
                n_dxi     = '0;
                n_rowbase = r_rowbase + CELL_AW'(gw);
                if (r_dyi == 3'd4) begin
                    n_state = S_DECIDE;
                end else begin
                    n_dyi   = r_dyi + 3'd1;
                    n_state = S_NB;
                end
            end else begin
                n_dxi   = r_dxi + 3'd1;
                n_state = S_NB;
            end
        end
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gw_cfg   <= DIM_W'(64);
            r_gh_cfg   <= DIM_W'(64);
            r_min_dist <= DIST_W'(65536);
            r_inv      <= INV_W'(65536);
        end else if (i_cfg_we) begin
            case (t_cfg_reg'(i_cfg_idx))
                REG_GRID_WIDTH:    r_gw_cfg   <= i_cfg_wdata[DIM_W-1:0];
                REG_GRID_HEIGHT:   r_gh_cfg   <= i_cfg_wdata[DIM_W-1:0];
                REG_MIN_DIST_SQ:   r_min_dist <= i_cfg_wdata[DIST_W-1:0];
                REG_INV_CELL_SIZE: r_inv      <= i_cfg_wdata[INV_W-1:0];
                default: ;
            endcase
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (in_acc && (i_s_tuser == OP_CLEAR)) begin
                r_count <= '0;
            end else if (r_state == S_DECIDE && insert_ok) begin
                r_count <= r_count + CNT_W'(1);
            end
            if (r_state == S_DONE && out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_mul     <= mul_a * mul_b;
        r_dxi     <= n_dxi;
        r_dyi     <= n_dyi;
        r_rowbase <= n_rowbase;
        r_close   <= n_close;
        if (in_acc) begin
            r_x          <= i_s_tdata[COORD_BITS-1:0];
            r_y          <= i_s_tdata[2*COORD_BITS-1:COORD_BITS];
            r_res_status <= ST_ACCEPT;
            r_res_idx    <= '0;
        end
        if (r_state == S_MULY) begin
            r_cx <= r_mul[FRAC_SH +: COORD_BITS];
        end
        if (r_state == S_BASE) begin
            r_cy <= r_mul[FRAC_SH +: COORD_BITS];
        end
        if (r_state == S_ROW) begin
            r_base0 <= r_mul[CELL_AW-1:0];
        end
        if (r_state == S_NB) begin
            r_caddr <= nb_addr;
        end
        if (r_state == S_DY) begin
            r_acc <= r_mul;
        end
        if (r_state == S_DECIDE) begin
            if (r_close) begin
                r_res_status <= ST_TOO_CLOSE;
            end else if (outside) begin
                r_res_status <= ST_OUTSIDE;
            end else if (!insert_ok) begin
                r_res_status <= ST_FULL;
            end else begin
                r_res_status <= ST_ACCEPT;
                r_res_idx    <= r_count[PIDX_W-1:0];
            end
        end
        if (r_state == S_DONE && out_free) begin
            r_out_status <= r_res_status;
            r_out_idx    <= r_res_idx;
            r_out_count  <= r_count;
        end
    end

    // cell table: point index per cell
    pdg_ram #(
        .WIDTH (PIDX_W),
        .DEPTH (CELLS)
    ) u_cell_ram (
        .i_clk   (i_clk),
        .i_we    (cell_we),
        .i_waddr (own_addr),
        .i_wdata (r_count[PIDX_W-1:0]),
        .i_re    (cell_re),
        .i_raddr (nb_addr),
        .o_rdata (cell_rdata)
    );

    // point store: {cell address, y, x}
    pdg_ram #(
        .WIDTH (PT_W),
        .DEPTH (MAX_POINTS)
    ) u_pt_ram (
        .i_clk   (i_clk),
        .i_we    (pt_we),
        .i_waddr (r_count[PIDX_W-1:0]),
        .i_wdata ({own_addr, r_y, r_x}),
        .i_re    (pt_re),
        .i_raddr (cell_rdata),
        .o_rdata (pt_rdata)
    );

    // ports
    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = OUT_DATA_W'({r_out_count, r_out_idx, r_out_status});

    // checks
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_POINTS))
        else $error("point count above store size");

    a_clear_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_s_tuser == OP_CLEAR) |=> (r_count == '0))
        else $error("clear did not empty the store");

    a_insert_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DECIDE && insert_ok) |=> (r_count == $past(r_count) + CNT_W'(1)))
        else $error("accepted point not counted");

    a_reject_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_status != ST_ACCEPT) |-> (r_out_idx == '0))
        else $error("rejected item carries a point index");

    a_accept_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_status == ST_ACCEPT && r_out_count != '0)
            |-> (r_out_count == {1'b0, r_out_idx} + CNT_W'(1)))
        else $error("accepted index does not match the count");

endmodule

`default_nettype wire
